### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the multiply-accumulate block.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### rtl/mma_pkg.sv
// Constants, codes and helpers of the scaled matrix multiply-accumulate block.
// No dependencies; used by matrix_multiply_accumulate_top.
`default_nettype none

package mma_pkg;

  // Store geometry and value format
  localparam int MAX_DIM    = 32;
  localparam int DATA_WIDTH = 16;
  localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM);

  // Field widths fixed by the interface
  localparam int IDX_W      = 5;
  localparam int SIZE_W     = 6;
  localparam int GAIN_W     = 16;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Arithmetic widths
  localparam int PROD_W   = 2 * DATA_WIDTH;
  localparam int ACC_W    = 40;
  localparam int ACC_LO_W = 20;
  localparam int ACC_HI_W = ACC_W - ACC_LO_W;
  localparam int MLO_W    = GAIN_W + ACC_LO_W + 1;
  localparam int MHI_W    = GAIN_W + ACC_HI_W;
  localparam int BZ_W     = GAIN_W + DATA_WIDTH;
  localparam int TOT_W    = 58;
  localparam int FRAC_SH  = 24;
  localparam int BZ_SH    = 12;

  // Stream widths, padded to whole bytes
  localparam int S_TDATA_W = ((2 * IDX_W + DATA_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_WIDTH + 2 * IDX_W + 7) / 8) * 8;

  localparam logic signed [TOT_W-1:0] ROUND_HALF = TOT_W'(1) <<< (FRAC_SH - 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_X  = 2'd0,
    ACT_LOAD_Y  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_K = 3'd0,
    CFG_SIZE_M = 3'd1,
    CFG_SIZE_N = 3'd2,
    CFG_ALPHA  = 3'd3,
    CFG_BETA   = 3'd4
  } cfg_reg_e;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_RUN      = 7'b0000010,
    ST_DRAIN    = 7'b0000100,
    ST_SCALE_LO = 7'b0001000,
    ST_SCALE_HI = 7'b0010000,
    ST_SUM      = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_e;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    return (int'(v) > MAX_DIM) ? SIZE_W'(MAX_DIM) : v;
  endfunction

  // Row-major store address
  function automatic logic [ADDR_W-1:0] addr_of(input logic [SIZE_W-1:0] r,
                                                 input logic [SIZE_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
  endfunction

endpackage

`default_nettype wire

### rtl/matrix_multiply_accumulate_top.sv
// Scaled matrix multiply-accumulate, Z = beta*Z + alpha*X*Y, one Z element per request.
// Depends on mma_pkg and assert_macros.svh.
//
// Usage:
//  - Slave stream: tuser carries the action (load X, load Y, compute Z); tdata
//    carries row, column and a Q4.12 operand. Loads write the X or Y store and
//    give no result; a compute request carries the old Z element.
//  - Master stream: one result per compute request; tdata holds the new Z,
//    its row and column, tlast marks element (M-1, N-1), tuser flags clipping.
//  - Config port: size_k/m/n, alpha, beta written by index; writing only while idle is up to the user.
//  - Timing: loads leave the block idle, so the slave side stays open for the next
//    request. A compute request closes the slave side until its result is loaded;
//    with K = 0 nothing is read. The pace is set by the single read port of each
//    store feeding one MAC: one stored pair per cycle, plus read, multiply and
//    accumulate stages and four scaling steps (two half-width multiplies of
//    alpha, a sum, a round/clip).
//  - A finished result waits in the output register; the slave side stays
//    open meanwhile. If the receiver stalls, the next compute request stops
//    in its last cycle until the waiting result is taken.
//  - Reset clears control and loads the register defaults; the stores keep
//    whatever they held and must be loaded before use.
`default_nettype none

`include "assert_macros.svh"

module matrix_multiply_accumulate_top (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // Slave stream
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [mma_pkg::S_TDATA_W-1:0]         s_axis_tdata,  // row_index, col_index, operand_value
  input  wire  [mma_pkg::ACTION_W-1:0]          s_axis_tuser,  // action
  // Master stream
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [mma_pkg::M_TDATA_W-1:0]         m_axis_tdata,  // z_value, z_row, z_col
  output logic                                  m_axis_tlast,  // z_last
  output logic                                  m_axis_tuser,  // saturated
  // Config write port
  input  wire                                   cfg_we_i,
  input  wire  [mma_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [mma_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        [mma_pkg::SIZE_W-1:0] size_k_q, size_m_q, size_n_q;
  logic signed [mma_pkg::GAIN_W-1:0] alpha_q, beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_k_q <= mma_pkg::SIZE_W'(32);
      size_m_q <= mma_pkg::SIZE_W'(32);
      size_n_q <= mma_pkg::SIZE_W'(32);
      alpha_q  <= mma_pkg::GAIN_W'(4096);
      beta_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mma_pkg::CFG_SIZE_K: size_k_q <= mma_pkg::clamp_size(cfg_data_i[mma_pkg::SIZE_W-1:0]);
        mma_pkg::CFG_SIZE_M: size_m_q <= mma_pkg::clamp_size(cfg_data_i[mma_pkg::SIZE_W-1:0]);
        mma_pkg::CFG_SIZE_N: size_n_q <= mma_pkg::clamp_size(cfg_data_i[mma_pkg::SIZE_W-1:0]);
        mma_pkg::CFG_ALPHA:  alpha_q  <= $signed(cfg_data_i[mma_pkg::GAIN_W-1:0]);
        mma_pkg::CFG_BETA:   beta_q   <= $signed(cfg_data_i[mma_pkg::GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic                                   in_acc;
  logic        [mma_pkg::ACTION_W-1:0]    in_action;
  logic        [mma_pkg::IDX_W-1:0]       in_row, in_col;
  logic signed [mma_pkg::DATA_WIDTH-1:0]  in_val;
  logic                                   in_row_ok, in_col_ok;
  logic        [mma_pkg::ADDR_W-1:0]      wr_addr;
  logic                                   x_we, y_we, start;

  assign in_action = s_axis_tuser;
  assign in_row    = s_axis_tdata[mma_pkg::IDX_W-1:0];
  assign in_col    = s_axis_tdata[2*mma_pkg::IDX_W-1:mma_pkg::IDX_W];
  assign in_val    = $signed(s_axis_tdata[2*mma_pkg::IDX_W +: mma_pkg::DATA_WIDTH]);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_row_ok = int'(in_row) < mma_pkg::MAX_DIM;
  assign in_col_ok = int'(in_col) < mma_pkg::MAX_DIM;
  assign wr_addr   = mma_pkg::addr_of(mma_pkg::SIZE_W'(in_row), mma_pkg::SIZE_W'(in_col));

  // loads outside the store are dropped
  assign x_we  = in_acc && in_action == mma_pkg::ACT_LOAD_X && in_row_ok && in_col_ok;
  assign y_we  = in_acc && in_action == mma_pkg::ACT_LOAD_Y && in_row_ok && in_col_ok;
  assign start = in_acc && in_action == mma_pkg::ACT_COMPUTE;

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  mma_pkg::state_e state_q, state_d;
  logic [mma_pkg::SIZE_W-1:0] k_q, k_d, k_lim_q;
  logic rd_en, rd_vld_q, prod_vld_q, out_load, m_tvalid_q;

  assign s_axis_tready = (state_q == mma_pkg::ST_IDLE);

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      mma_pkg::ST_IDLE: begin
        if (start) begin
          k_d     = '0;
          // empty sum skips the reads and goes to the drain state
          state_d = (size_k_q == '0) ? mma_pkg::ST_DRAIN : mma_pkg::ST_RUN;
        end
      end
      mma_pkg::ST_RUN: begin
        rd_en = 1'b1;
        if (k_q == k_lim_q - mma_pkg::SIZE_W'(1)) begin
          state_d = mma_pkg::ST_DRAIN;
        end else begin
          k_d = k_q + mma_pkg::SIZE_W'(1);
        end
      end
      mma_pkg::ST_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = mma_pkg::ST_SCALE_LO;
        end
      end
      mma_pkg::ST_SCALE_LO: state_d = mma_pkg::ST_SCALE_HI;
      mma_pkg::ST_SCALE_HI: state_d = mma_pkg::ST_SUM;
      mma_pkg::ST_SUM:      state_d = mma_pkg::ST_FINISH;
      mma_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!m_tvalid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = mma_pkg::ST_IDLE;
        end
      end
      default: state_d = mma_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mma_pkg::ST_IDLE;
      k_q        <= '0;
      k_lim_q    <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      rd_vld_q   <= rd_en;
      prod_vld_q <= rd_vld_q;
      if (start) begin
        k_lim_q <= size_k_q;
      end
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // X and Y stores: one write or one read per cycle each, registered read.
  // Writes happen only in idle, reads only while running, so no overlap.
  // ---------------------------------------------------------------------------
  logic        [mma_pkg::IDX_W-1:0]      row_q, col_q;
  logic                                  row_ok_q, col_ok_q;
  logic signed [mma_pkg::DATA_WIDTH-1:0] val_q;
  logic        [mma_pkg::ADDR_W-1:0]     x_raddr, y_raddr;

  logic [mma_pkg::DATA_WIDTH-1:0] x_mem [mma_pkg::MAX_DIM*mma_pkg::MAX_DIM];
  logic [mma_pkg::DATA_WIDTH-1:0] y_mem [mma_pkg::MAX_DIM*mma_pkg::MAX_DIM];
  logic [mma_pkg::DATA_WIDTH-1:0] x_rd_q, y_rd_q;

  assign x_raddr = mma_pkg::addr_of(mma_pkg::SIZE_W'(row_q), k_q);
  assign y_raddr = mma_pkg::addr_of(k_q, mma_pkg::SIZE_W'(col_q));

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      x_mem[wr_addr] <= in_val;
    end
    if (rd_en) begin
      x_rd_q <= x_mem[x_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (y_we) begin
      y_mem[wr_addr] <= in_val;
    end
    if (rd_en) begin
      y_rd_q <= y_mem[y_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // MAC and scaling datapath
  // ---------------------------------------------------------------------------
  logic signed [mma_pkg::DATA_WIDTH-1:0] x_op, y_op;
  logic signed [mma_pkg::PROD_W-1:0]     prod_q;
  logic signed [mma_pkg::ACC_W-1:0]      acc_q;
  logic signed [mma_pkg::MLO_W-1:0]      mul_lo_q;
  logic signed [mma_pkg::MHI_W-1:0]      mul_hi_q;
  logic signed [mma_pkg::BZ_W-1:0]       bz_q;
  logic signed [mma_pkg::TOT_W-1:0]      sum_q, total;
  logic [mma_pkg::TOT_W-mma_pkg::FRAC_SH-mma_pkg::DATA_WIDTH:0] total_top;
  logic sat_pos, sat_neg;

  logic signed [mma_pkg::DATA_WIDTH-1:0] z_q;
  logic        [mma_pkg::IDX_W-1:0]      z_row_q, z_col_q;
  logic                                  z_last_q, z_sat_q;

  // an X row or Y column outside the store reads as zero
  assign x_op = row_ok_q ? $signed(x_rd_q) : '0;
  assign y_op = col_ok_q ? $signed(y_rd_q) : '0;

  // round half up, then clip to the output range
  assign total     = sum_q + (mma_pkg::TOT_W'(bz_q) <<< mma_pkg::BZ_SH);
  assign total_top = total[mma_pkg::TOT_W-1:mma_pkg::FRAC_SH+mma_pkg::DATA_WIDTH-1];
  assign sat_pos   = !total[mma_pkg::TOT_W-1] && (|total_top);
  assign sat_neg   = total[mma_pkg::TOT_W-1] && !(&total_top);

  always_ff @(posedge clk_i) begin
    if (start) begin
      row_q    <= in_row;
      col_q    <= in_col;
      row_ok_q <= in_row_ok;
      col_ok_q <= in_col_ok;
      val_q    <= in_val;
      acc_q    <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + mma_pkg::ACC_W'(prod_q);
    end
    if (rd_vld_q) begin
      prod_q <= x_op * y_op;
    end
    if (state_q == mma_pkg::ST_SCALE_LO) begin
      mul_lo_q <= alpha_q * $signed({1'b0, acc_q[mma_pkg::ACC_LO_W-1:0]});
      bz_q     <= beta_q * val_q;
    end
    if (state_q == mma_pkg::ST_SCALE_HI) begin
      mul_hi_q <= alpha_q * $signed(acc_q[mma_pkg::ACC_W-1:mma_pkg::ACC_LO_W]);
    end
    if (state_q == mma_pkg::ST_SUM) begin
      sum_q <= (mma_pkg::TOT_W'(mul_hi_q) <<< mma_pkg::ACC_LO_W)
             + mma_pkg::TOT_W'(mul_lo_q) + mma_pkg::ROUND_HALF;
    end
    if (out_load) begin
      if (sat_pos) begin
        z_q <= {1'b0, {(mma_pkg::DATA_WIDTH-1){1'b1}}};
      end else if (sat_neg) begin
        z_q <= {1'b1, {(mma_pkg::DATA_WIDTH-1){1'b0}}};
      end else begin
        z_q <= total[mma_pkg::FRAC_SH +: mma_pkg::DATA_WIDTH];
      end
      z_sat_q  <= sat_pos || sat_neg;
      z_row_q  <= row_q;
      z_col_q  <= col_q;
      z_last_q <= size_m_q != '0 && size_n_q != '0
               && mma_pkg::SIZE_W'(row_q) == size_m_q - mma_pkg::SIZE_W'(1)
               && mma_pkg::SIZE_W'(col_q) == size_n_q - mma_pkg::SIZE_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Output
  // ---------------------------------------------------------------------------
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = mma_pkg::M_TDATA_W'({z_col_q, z_row_q, z_q});
  assign m_axis_tlast  = z_last_q;
  assign m_axis_tuser  = z_sat_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic mac_phase;

  assign mac_phase = (state_q == mma_pkg::ST_RUN) || (state_q == mma_pkg::ST_DRAIN);

  `ASSERT_CLK(a_idle_pipe_empty, s_axis_tready |-> !rd_vld_q && !prod_vld_q, "MAC pipe busy in idle")
  `ASSERT_CLK(a_k_in_range, state_q == mma_pkg::ST_RUN |-> k_q < k_lim_q, "k beyond size_k")
  `ASSERT_CLK(a_no_overwrite, out_load |-> !m_tvalid_q || m_axis_tready, "result overwritten")
  `ASSERT_NEVER(a_acc_outside_mac, prod_vld_q && !mac_phase, "accumulate outside MAC phase")

endmodule

`default_nettype wire
